// File: hdl/skl_pkg.sv
// Shared types and codes of the sorted key list unit.
package skl_pkg;

   // Width of one stored key.
   localparam int KEY_WIDTH = 32;
   // Width of the rank field of a request.
   localparam int RANK_WIDTH = 8;
   // Width of the entry count field of a response.
   localparam int COUNT_WIDTH = 7;

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_GET    = 2'd2,
      REQ_SEARCH = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      req_kind_type                 req_type;
      logic signed [KEY_WIDTH-1:0]  key_value;
      logic signed [RANK_WIDTH-1:0] rank;
   } req_beat_type;

   typedef struct packed {
      status_type                   status;
      logic signed [KEY_WIDTH-1:0]  result_key;
      logic [COUNT_WIDTH-1:0]       entry_count;
   } rsp_beat_type;

   // Command broadcast from the control logic to every cell of the row.
   typedef struct packed {
      logic                        push_en;
      logic                        pop_en;
      logic signed [KEY_WIDTH-1:0] key;
   } cell_cmd_type;

   // What a cell reports back about its own entry.
   typedef struct packed {
      logic ge;
      logic eq;
   } cell_flags_type;

endpackage

// File: hdl/sorted_key_list_unit.sv
// Top level of the sorted key list: a row of key cells kept in ascending order.
// A response beat is registered and appears in the cycle after its request beat is taken.
// Throughput: one request per cycle while responses are taken; every cell compares and shifts as it is taken.
// The output register takes a new request in the cycle its previous response is taken,
// so a stalled response holds off further requests until it drains.
// Reset clears the entry count and the response valid; the key cells keep their
// contents, as only cells below the count are ever read.
module sorted_key_list_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  skl_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output skl_pkg::rsp_beat_type rsp_data
);

   // Count width holds the value CAPACITY itself; the select width also covers
   // every non-negative rank.
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (CW > skl_pkg::RANK_WIDTH - 1) ? CW : skl_pkg::RANK_WIDTH - 1;

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   skl_pkg::rsp_beat_type  rsp_data_ff;
   skl_pkg::rsp_beat_type  rsp_data_in;

   logic                   accept;
   logic                   full;
   logic                   empty;
   logic [SW-1:0]          get_pos;
   logic                   get_ok;
   logic                   search_hit;
   logic signed [skl_pkg::KEY_WIDTH-1:0] get_key;
   skl_pkg::cell_cmd_type  cmd;

   logic signed [skl_pkg::KEY_WIDTH-1:0] cell_key [CAPACITY];
   skl_pkg::cell_flags_type              cell_flags [CAPACITY];
   logic [CAPACITY-1:0]                  occupied;
   logic [CAPACITY-1:0]                  get_hit;

   // The response register is free when it is empty or being drained in this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);

   // A negative rank reads as rank zero.
   assign get_pos = req_data.rank[skl_pkg::RANK_WIDTH-1] ? '0
                  : SW'(req_data.rank[skl_pkg::RANK_WIDTH-2:0]);
   assign get_ok  = get_pos < SW'(count_ff);

   // Only a push that fits and a pop of a non-empty list change the row.
   assign cmd.push_en = accept && (req_data.req_type == skl_pkg::REQ_PUSH) && !full;
   assign cmd.pop_en  = accept && (req_data.req_type == skl_pkg::REQ_POP) && !empty;
   assign cmd.key     = req_data.key_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                  left_ge;
      logic signed [skl_pkg::KEY_WIDTH-1:0]  left_key;
      logic signed [skl_pkg::KEY_WIDTH-1:0]  right_key;

      assign occupied[i] = CW'(i) < count_ff;
      assign get_hit[i]  = occupied[i] && (SW'(i) == get_pos);

      if (i == 0) begin : g_head
         assign left_ge  = 1'b0;
         assign left_key = '0;
      end else begin : g_body
         assign left_ge  = cell_flags[i-1].ge;
         assign left_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      skl_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (occupied[i]),
         .at_tail   (CW'(i) == count_ff),
         .left_ge   (left_ge),
         .left_key  (left_key),
         .right_key (right_key),
         .cell_key  (cell_key[i]),
         .flags     (cell_flags[i])
      );
   end

   // At most one cell matches the rank, so an AND-OR select picks its key.
   always_comb begin
      get_key    = '0;
      search_hit = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         get_key    = get_key | (get_hit[i] ? cell_key[i] : '0);
         search_hit = search_hit | cell_flags[i].eq;
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.push_en) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_en) begin
         count_in = count_ff - CW'(1);
      end
      if (accept) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.status     = skl_pkg::STATUS_MISS;
         rsp_data_in.result_key = '0;
         rsp_data_in.entry_count = skl_pkg::COUNT_WIDTH'(count_in);
         case (req_data.req_type)
            skl_pkg::REQ_PUSH: begin
               rsp_data_in.status = full ? skl_pkg::STATUS_FULL : skl_pkg::STATUS_OK;
            end
            skl_pkg::REQ_POP: begin
               if (!empty) begin
                  rsp_data_in.status     = skl_pkg::STATUS_OK;
                  rsp_data_in.result_key = cell_key[0];
               end
            end
            skl_pkg::REQ_GET: begin
               if (get_ok) begin
                  rsp_data_in.status     = skl_pkg::STATUS_OK;
                  rsp_data_in.result_key = get_key;
               end
            end
            skl_pkg::REQ_SEARCH: begin
               if (search_hit) begin
                  rsp_data_in.status     = skl_pkg::STATUS_OK;
                  rsp_data_in.result_key = req_data.key_value;
               end
            end
            default: begin
               rsp_data_in.status = skl_pkg::STATUS_MISS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: hdl/skl_cell.sv
// One storage cell of the sorted key row, with its compare and shift logic.
module skl_cell (
   input  logic                                  clock,
   input  skl_pkg::cell_cmd_type                 cmd,
   input  logic                                  occupied,
   input  logic                                  at_tail,
   input  logic                                  left_ge,
   input  logic signed [skl_pkg::KEY_WIDTH-1:0]  left_key,
   input  logic signed [skl_pkg::KEY_WIDTH-1:0]  right_key,
   output logic signed [skl_pkg::KEY_WIDTH-1:0]  cell_key,
   output skl_pkg::cell_flags_type               flags
);

   logic signed [skl_pkg::KEY_WIDTH-1:0] cell_key_ff;
   logic signed [skl_pkg::KEY_WIDTH-1:0] cell_key_in;

   // The entry is at or above the incoming key, so the key goes in front of it.
   assign flags.ge = occupied && (cmd.key <= cell_key_ff);
   assign flags.eq = occupied && (cmd.key == cell_key_ff);
   assign cell_key = cell_key_ff;

   always_comb begin
      cell_key_in = cell_key_ff;
      if (cmd.push_en) begin
         if (left_ge) begin
            cell_key_in = left_key;
         end else if (flags.ge || at_tail) begin
            cell_key_in = cmd.key;
         end
      end else if (cmd.pop_en) begin
         cell_key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      cell_key_ff <= cell_key_in;
   end

endmodule

// File: hdl/skl_checker.sv
// Port-level checks of the sorted key list unit, bound to its top level.
module skl_checker #(
   parameter int CAPACITY = 64
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input skl_pkg::req_beat_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input skl_pkg::rsp_beat_type rsp_data
);

   // A response beat that is not taken stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // Every accepted request yields a response in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // No response is pending straight after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A rejected push is only reported with the list at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == skl_pkg::STATUS_FULL)
      |-> rsp_data.entry_count == skl_pkg::COUNT_WIDTH'(CAPACITY))
      else $error("full status with list below capacity");

   // Any status other than success carries a zero key.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != skl_pkg::STATUS_OK) |-> rsp_data.result_key == '0)
      else $error("non-zero key with failure status");

endmodule

bind sorted_key_list_unit skl_checker #(.CAPACITY(CAPACITY)) u_skl_checker (.*);

// File: bench/tb.sv
// Self-checking bench for the sorted key list unit, with random handshake pressure.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import skl_pkg::*;

   // The clock period is 8 ns, so the clock inverts every 4 ns.
   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 8;
   localparam int CAPACITY = 64;
   localparam int RANDOM_BEATS = 400;
   // A response beat appears in the cycle after its request beat is taken. The tail wait after the last
   // expected response lets a stray extra beat still be seen.
   localparam int TAIL_CYCLES = 10;
   // This many cycles in a row with no beat on either channel means the unit has hung.
   localparam int STALL_LIMIT = 2000;
   // Each side idles in roughly this many cycles out of a hundred.
   localparam int IDLE_PERCENT = 19;
   // Between these two counts of accepted request beats, neither side idles at random.
   localparam int CALM_FIRST = 180;
   localparam int CALM_LAST = 300;
   localparam int MAX_REPORTS = 10;

   localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   // A request beat waiting to be driven. When hold_for_drain is set, the driver keeps the
   // channel quiet until every response that is already owed has come back.
   typedef struct packed {
      logic         hold_for_drain;
      req_beat_type beat;
   } pending_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_beat_type rsp_data;

   pending_beat_type pending_beats[$];
   rsp_beat_type owed_responses[$];

   // The list as the bench believes the unit holds it, smallest key at the front.
   logic signed [KEY_WIDTH-1:0] held_keys[$];

   // Bookkeeping of the stimulus generator: how many keys the list will hold once every
   // queued beat has been taken, and a short history of pushed keys for duplicates and hits.
   int planned_count = 0;
   logic signed [KEY_WIDTH-1:0] key_history[$];

   logic req_taken = 1'b0;
   int beats_taken = 0;
   int quiet_cycles = 0;
   bit timed_out = 1'b0;
   int fault_count = 0;

   sorted_key_list_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Applies one request to the believed list and returns the response the unit owes for it.
   // A push goes in front of any equal keys already held; a full list refuses it. A pop of
   // an empty list and a get or search that finds nothing leave the list alone and report a
   // miss with a zero key. A negative rank reads the smallest key.
   function automatic rsp_beat_type apply_request(input req_beat_type beat);
      rsp_beat_type outcome;
      int slot;
      int held_size;
      bit placed;
      outcome.status = STATUS_MISS;
      outcome.result_key = '0;
      case (beat.req_type)
         REQ_PUSH: begin
            if (held_keys.size() >= CAPACITY) begin
               outcome.status = STATUS_FULL;
            end else begin
               slot = held_keys.size();
               placed = 1'b0;
               for (int i = 0; i < held_keys.size(); i++) begin
                  if (!placed && beat.key_value <= held_keys[i]) begin
                     slot = i;
                     placed = 1'b1;
                  end
               end
               held_keys.insert(slot, beat.key_value);
               outcome.status = STATUS_OK;
            end
         end
         REQ_POP: begin
            if (held_keys.size() != 0) begin
               outcome.result_key = held_keys.pop_front();
               outcome.status = STATUS_OK;
            end
         end
         REQ_GET: begin
            slot = beat.rank[RANK_WIDTH-1] ? 0 : int'(beat.rank);
            if (slot < held_keys.size()) begin
               outcome.result_key = held_keys[slot];
               outcome.status = STATUS_OK;
            end
         end
         default: begin
            foreach (held_keys[i]) begin
               if (held_keys[i] == beat.key_value) begin
                  outcome.result_key = beat.key_value;
                  outcome.status = STATUS_OK;
               end
            end
         end
      endcase
      held_size = held_keys.size();
      outcome.entry_count = held_size[COUNT_WIDTH-1:0];
      return outcome;
   endfunction

   // Picks a key: sometimes one pushed recently, so that duplicates and search hits occur,
   // sometimes an extreme of the range, zero or minus one, otherwise any 32-bit pattern.
   function automatic logic signed [KEY_WIDTH-1:0] draw_key(input bit favour_known);
      int roll;
      roll = $urandom_range(99);
      if (key_history.size() != 0 && (favour_known ? roll < 55 : roll < 25)) begin
         return key_history[$urandom_range(key_history.size() - 1)];
      end
      if (roll >= 88) begin
         case (roll % 4)
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // Appends one request beat to the stimulus and keeps the planned count in step with it.
   task automatic queue_beat(input req_kind_type kind, input logic signed [KEY_WIDTH-1:0] key,
                             input logic signed [RANK_WIDTH-1:0] rank, input bit hold);
      pending_beat_type item;
      item.hold_for_drain = hold;
      item.beat.req_type = kind;
      item.beat.key_value = key;
      item.beat.rank = rank;
      pending_beats.push_back(item);
      if (kind == REQ_PUSH && planned_count < CAPACITY) begin
         planned_count++;
         key_history.push_back(key);
         if (key_history.size() > 24) begin
            void'(key_history.pop_front());
         end
      end else if (kind == REQ_POP && planned_count > 0) begin
         planned_count--;
      end
   endtask

   // Counts a failure and reports the first few of them in full.
   task automatic log_fault(input string text);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("mismatch at %0t ns: %s", $realtime, text);
      end
   endtask

   // Driver. Both channels change on the falling edge only, so the unit sees stable inputs
   // at every rising edge. A request beat stays on the bus, unchanged, until it is taken;
   // only then may the driver idle or move on to the next pending beat.
   always @(negedge clock) begin : drive_channels
      pending_beat_type next_item;
      bit calm;
      bit may_send;
      calm = beats_taken >= CALM_FIRST && beats_taken < CALM_LAST;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         if (!req_valid || req_taken) begin
            may_send = pending_beats.size() != 0;
            if (may_send && pending_beats[0].hold_for_drain && owed_responses.size() != 0) begin
               may_send = 1'b0;
            end
            if (may_send && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_item = pending_beats.pop_front();
               req_data <= next_item.beat;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and predictor. At each rising edge a response beat that is taken is checked
   // against the oldest owed response first; a request beat taken at the same edge is then
   // predicted and joins the back of the queue. The watchdog counts edges with no beat.
   always @(posedge clock) begin : watch_channels
      rsp_beat_type wanted;
      bit any_beat;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         any_beat = 1'b0;
         if (rsp_valid && rsp_ready) begin
            any_beat = 1'b1;
            if (owed_responses.size() == 0) begin
               log_fault($sformatf("response beat with none owed (status %0d key %0d count %0d)",
                                   rsp_data.status, rsp_data.result_key, rsp_data.entry_count));
            end else begin
               wanted = owed_responses.pop_front();
               if (rsp_data.status !== wanted.status) begin
                  log_fault($sformatf("status expected %0d, got %0d",
                                      wanted.status, rsp_data.status));
               end
               if (rsp_data.result_key !== wanted.result_key) begin
                  log_fault($sformatf("result_key expected %0d, got %0d",
                                      wanted.result_key, rsp_data.result_key));
               end
               if (rsp_data.entry_count !== wanted.entry_count) begin
                  log_fault($sformatf("entry_count expected %0d, got %0d",
                                      wanted.entry_count, rsp_data.entry_count));
               end
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            any_beat = 1'b1;
            beats_taken++;
            owed_responses.push_back(apply_request(req_data));
         end
         quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            timed_out = 1'b1;
         end
      end
   end

   // Builds the whole stimulus up front, releases reset, then waits for the traffic to end.
   initial begin : run_test
      int roll;
      int rank_draw;
      int overfills;
      int underflows;
      bit filling;
      req_kind_type kind;
      logic signed [RANK_WIDTH-1:0] pick_rank;

      // Directed beats. The empty list first: pop, get and search all miss.
      queue_beat(REQ_POP, 32'sd7, 8'sd0, 1'b0);
      queue_beat(REQ_GET, 32'sd0, 8'sd0, 1'b0);
      queue_beat(REQ_SEARCH, 32'sd5, 8'sd0, 1'b0);
      // Both extremes of the key range, zero, minus one, and a second zero that must land
      // in front of the first.
      queue_beat(REQ_PUSH, KEY_MAX, 8'sd0, 1'b0);
      queue_beat(REQ_PUSH, KEY_MIN, 8'sd0, 1'b0);
      queue_beat(REQ_PUSH, 32'sd0, 8'sd0, 1'b0);
      queue_beat(REQ_PUSH, -32'sd1, 8'sd0, 1'b0);
      queue_beat(REQ_PUSH, 32'sd0, 8'sh7F, 1'b0);
      // Ranks: the most negative and minus one both read the smallest key; 127 and the
      // count itself are out of range; the last held key is rank four.
      queue_beat(REQ_GET, 32'sd3, 8'sh80, 1'b0);
      queue_beat(REQ_GET, 32'sd0, 8'sh7F, 1'b0);
      queue_beat(REQ_GET, 32'sd0, -8'sd1, 1'b0);
      queue_beat(REQ_GET, 32'sd0, 8'sd4, 1'b0);
      queue_beat(REQ_GET, 32'sd0, 8'sd5, 1'b0);
      // Searches: hits at both ends and in the middle, misses between and beside keys.
      queue_beat(REQ_SEARCH, KEY_MIN, 8'sd0, 1'b0);
      queue_beat(REQ_SEARCH, KEY_MAX, 8'sd0, 1'b0);
      queue_beat(REQ_SEARCH, 32'sd0, 8'sd0, 1'b0);
      queue_beat(REQ_SEARCH, 32'sd1, 8'sd0, 1'b0);
      queue_beat(REQ_SEARCH, KEY_MAX - 1, 8'sd0, 1'b0);
      queue_beat(REQ_SEARCH, KEY_MIN + 1, 8'sd0, 1'b0);
      queue_beat(REQ_POP, 32'sd0, 8'sd0, 1'b0);
      queue_beat(REQ_POP, -32'sd9, 8'sh80, 1'b0);
      queue_beat(REQ_GET, 32'sd0, 8'sd0, 1'b0);

      // Random beats in alternating phases: a filling phase, mostly pushes, runs until a
      // few pushes have been refused by the full list; a draining phase, mostly pops, runs
      // until a few pops have hit the empty list. Gets and searches are mixed in throughout.
      filling = 1'b1;
      overfills = 0;
      underflows = 0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         roll = $urandom_range(99);
         if (filling) begin
            kind = roll < 70 ? REQ_PUSH : roll < 78 ? REQ_POP : roll < 89 ? REQ_GET : REQ_SEARCH;
         end else begin
            kind = roll < 60 ? REQ_POP : roll < 70 ? REQ_PUSH : roll < 85 ? REQ_GET : REQ_SEARCH;
         end
         if (kind == REQ_PUSH && planned_count == CAPACITY) begin
            overfills++;
         end
         if (kind == REQ_POP && planned_count == 0) begin
            underflows++;
         end
         // Ranks mostly fall around the live part of the list, from minus one to just
         // past the end; now and then any 8-bit pattern.
         if (kind != REQ_GET || $urandom_range(99) < 15) begin
            rank_draw = $urandom_range(255);
         end else begin
            rank_draw = $urandom_range(planned_count + 1) - 1;
         end
         pick_rank = rank_draw[RANK_WIDTH-1:0];
         // The first random beat and one halfway through wait for the list to go quiet.
         queue_beat(kind, draw_key(kind == REQ_SEARCH), pick_rank,
                    n == 0 || n == RANDOM_BEATS / 2);
         if (filling && planned_count == CAPACITY && overfills >= 3) begin
            filling = 1'b0;
            overfills = 0;
         end
         if (!filling && planned_count == 0 && underflows >= 2) begin
            filling = 1'b1;
            underflows = 0;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every beat has been taken and every owed response has come back.
      while (!timed_out &&
             (pending_beats.size() != 0 || req_valid || owed_responses.size() != 0)) begin
         @(negedge clock);
      end

      if (timed_out) begin
         $display("tb: failure");
      end else begin
         repeat (TAIL_CYCLES) @(posedge clock);
         if (fault_count == 0 && owed_responses.size() == 0) begin
            $display("tb: success");
         end else begin
            $display("tb: failure");
         end
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/skl_pkg.sv
hdl/skl_cell.sv
hdl/sorted_key_list_unit.sv
hdl/skl_checker.sv
bench/tb.sv
